[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ales_pkg.sv]
// ----------------------------------------------------------------------------
// ales_pkg
// Types and codes of the adjacency list edge store.
// ----------------------------------------------------------------------------
package ales_pkg;

  localparam int VERT_W   = 9;
  localparam int WEIGHT_W = 64;
  localparam int ID_W     = 13;
  localparam int POS_W    = 4;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_LIST   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_EDGE    = 3'd1,
    ST_WEIGHTLESS = 3'd2,
    ST_FULL       = 3'd3,
    ST_RANGE      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LEN,
    S_DECIDE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [VERT_W-1:0]   dst;
    logic [WEIGHT_W-1:0] weight;
    logic [ID_W-1:0]     id;
  } edge_t;

endpackage

[rtl/adjacency_list_edge_store_top.sv]
// ----------------------------------------------------------------------------
// adjacency_list_edge_store_top
// Per-vertex adjacency list store: insert, query and list over stored edges.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata / data                        | tuser | tlast
//  ---------+-----------+-------------------------------------+-------+------
//  s_*      | in        | src_vertex, dst_vertex, edge_weight | kind  | -
//  m_*      | out       | found .. status (see port comments) | -     | last
//  cfg_*    | in        | weighted_graph                      | -     | -
//
//  After reset the length table is cleared, one vertex a cycle; no input
//  beat is accepted until the sweep ends. Insert, error and empty replies:
//  S_LEN reads the list length, then S_DECIDE loads the output register.
//  Query: S_SCAN walks the slots in order to the first match or the end.
//  List: one beat per stored edge, one stored edge per edge memory read.
//  A stalled sink holds the sequencer; a new beat is accepted once the final
//  result of the current one sits in the output register.
//
module adjacency_list_edge_store_top #(
  parameter int VERTEX_COUNT = 256,
  parameter int MAX_DEGREE   = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        s_tvalid,
  output logic        s_tready,
  // [8:0] src_vertex, [17:9] dst_vertex, [81:18] edge_weight, [87:82] zero
  input  logic [87:0] s_tdata,
  // [1:0] kind
  input  logic [1:0]  s_tuser,
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] found, [4:1] position, [13:5] neighbour, [77:14] weight_out,
  // [90:78] edge_id, [93:91] status, [95:94] zero
  output logic [95:0] m_tdata,
  output logic        m_tlast,
  // configuration write: weighted_graph
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import ales_pkg::*;

  // vertex index, edge slot index and list length widths
  localparam int VW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int LW = $clog2(MAX_DEGREE + 1);

  state_t state, state_next;

  // latched item
  logic [1:0]          kind_q;
  logic [VERT_W-1:0]   dst_q;
  logic [WEIGHT_W-1:0] wt_q;
  logic                bad_q;
  logic [VW-1:0]       v_q;

  // list length table, cleared by the sweep after reset
  logic [LW-1:0] len_mem [2**VW];
  logic [LW-1:0] len_q;
  logic          len_we;
  logic [VW-1:0] len_wa;
  logic [LW-1:0] len_wd;
  logic [VW-1:0] clr_idx;

  // edge slots, one row of 2**IW per vertex
  edge_t         edge_mem [2**(VW+IW)];
  edge_t         edge_q;
  logic          edge_we;

  logic [IW-1:0] idx, idx_next;
  logic [ID_W-1:0] id_count, id_inc;
  logic          weighted;

  // input decode
  logic [VERT_W-1:0]   in_src, in_dst;
  logic [WEIGHT_W-1:0] in_wt;
  logic                in_accept, in_kind_ok, src_ok, dst_ok, in_bad;

  // result being formed and the output register
  logic                emit, out_free, hit, at_end;
  logic                r_found, r_last;
  logic [POS_W-1:0]    r_pos;
  logic [VERT_W-1:0]   r_nb;
  logic [WEIGHT_W-1:0] r_wt;
  logic [ID_W-1:0]     r_id;
  status_t             r_st;

  logic                o_found, o_last;
  logic [POS_W-1:0]    o_pos;
  logic [VERT_W-1:0]   o_nb;
  logic [WEIGHT_W-1:0] o_wt;
  logic [ID_W-1:0]     o_id;
  status_t             o_st;

  assign in_src     = s_tdata[8:0];
  assign in_dst     = s_tdata[17:9];
  assign in_wt      = s_tdata[81:18];
  assign in_accept  = s_tvalid && s_tready;
  assign in_kind_ok = (s_tuser == KIND_INSERT) || (s_tuser == KIND_QUERY) ||
                      (s_tuser == KIND_LIST);
  assign src_ok     = (in_src != '0) && ({23'd0, in_src} <= 32'(VERTEX_COUNT));
  assign dst_ok     = (in_dst != '0) && ({23'd0, in_dst} <= 32'(VERTEX_COUNT));
  assign in_bad     = !(src_ok && ((s_tuser == KIND_LIST) || dst_ok));

  assign out_free = !m_tvalid || m_tready;
  assign hit      = (edge_q.dst == dst_q);
  assign at_end   = (LW'(idx) + LW'(1) == len_q);
  assign id_inc   = id_count + ID_W'(1);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == VW'(VERTEX_COUNT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        // an unknown kind is dropped here without a result
        if (in_accept && in_kind_ok) state_next = S_LEN;
      end
      S_LEN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (emit) begin
          state_next = S_IDLE;
        end else if (!bad_q && (len_q != '0) && (kind_q != KIND_INSERT)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (emit && r_last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------- datapath and writes
  always_comb begin
    s_tready = (state == S_IDLE);
    emit     = 1'b0;
    r_found  = 1'b0;
    r_pos    = '0;
    r_nb     = '0;
    r_wt     = '0;
    r_id     = '0;
    r_st     = ST_OK;
    r_last   = 1'b1;
    len_we   = 1'b0;
    len_wa   = v_q;
    len_wd   = len_q + LW'(1);
    edge_we  = 1'b0;
    idx_next = idx;
    case (state)
      S_CLEAR: begin
        len_we = 1'b1;
        len_wa = clr_idx;
        len_wd = '0;
      end
      S_IDLE, S_LEN: begin
        idx_next = '0;
      end
      S_DECIDE: begin
        idx_next = '0;
        if (bad_q) begin
          emit = out_free;
          r_st = ST_RANGE;
        end else begin
          case (kind_q)
            KIND_INSERT: begin
              emit = out_free;
              if (len_q == LW'(MAX_DEGREE)) begin
                r_st = ST_FULL;
              end else begin
                r_id    = id_inc;
                // commit the edge only with the result beat
                len_we  = out_free;
                edge_we = out_free;
              end
            end
            KIND_QUERY: begin
              if (len_q == '0) begin
                emit = out_free;
                r_st = weighted ? ST_NO_EDGE : ST_WEIGHTLESS;
              end
            end
            default: begin
              // list of an empty vertex gives one empty result
              if (len_q == '0) emit = out_free;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (kind_q == KIND_QUERY) begin
          if (hit || at_end) begin
            emit = out_free;
            if (!weighted) begin
              r_found = hit;
              r_pos   = hit ? POS_W'(idx) : '0;
              r_st    = ST_WEIGHTLESS;
            end else if (hit) begin
              r_found = 1'b1;
              r_pos   = POS_W'(idx);
              r_wt    = edge_q.weight;
            end else begin
              r_st = ST_NO_EDGE;
            end
          end else begin
            idx_next = idx + IW'(1);
          end
        end else begin
          emit    = out_free;
          r_found = 1'b1;
          r_pos   = POS_W'(idx);
          r_nb    = edge_q.dst;
          r_wt    = edge_q.weight;
          r_id    = edge_q.id;
          r_last  = at_end;
          if (out_free) idx_next = idx + IW'(1);
        end
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  // ----------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      idx      <= '0;
      id_count <= '0;
      weighted <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + VW'(1);
      if (cfg_valid && cfg_ready) weighted <= cfg_data;
      if (edge_we) id_count <= id_inc;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // latch the item and the result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_q <= s_tuser;
      dst_q  <= in_dst;
      wt_q   <= in_wt;
      bad_q  <= in_bad;
      v_q    <= VW'(in_src - VERT_W'(1));
    end
    if (emit) begin
      o_found <= r_found;
      o_pos   <= r_pos;
      o_nb    <= r_nb;
      o_wt    <= r_wt;
      o_id    <= r_id;
      o_st    <= r_st;
      o_last  <= r_last;
    end
  end

  // length table: one write port, registered read at the latched vertex
  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    len_q <= len_mem[v_q];
  end

  // edge memory: read at the slot the scan will look at next cycle
  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[{v_q, IW'(len_q)}] <= '{dst: dst_q, weight: wt_q, id: id_inc};
    edge_q <= edge_mem[{v_q, idx_next}];
  end

  assign m_tdata = {2'b00, o_st, o_id, o_wt, o_nb, o_pos, o_found};
  assign m_tlast = o_last;

  // ---------------------------------------------------------------- assertions
  `include "assert_macros.svh"

  `ASSERT_IMPLIES(a_len_bound, state == S_DECIDE, len_q <= LW'(MAX_DEGREE), "list length above max")
  `ASSERT_IMPLIES(a_scan_nonempty, state == S_SCAN, len_q != '0, "scan of an empty list")
  `ASSERT_IMPLIES(a_err_last, m_tvalid && (o_st != ST_OK), m_tlast, "error beat not last")
  `ASSERT_NEXT(a_id_step, edge_we, id_count == ID_W'($past(id_count) + ID_W'(1)), "id skipped")

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adjacency list edge store. A short table of
// directed beats (empty lists, range errors, a list filled to capacity) runs
// first. Three random phases follow, with weighted_graph set, cleared, then
// set again. A mirror of the per-vertex edge lists predicts the result beats
// of all but the fixed rows; each result channel beat is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import ales_pkg::*;

  localparam int PERIOD         = 8;
  localparam int VERTICES       = 256;
  localparam int MAX_DEG        = 16;
  localparam int RAND_PER_PHASE = 80;   // counted beats per random phase
  localparam int HOT_VERTICES   = 5;    // few sources, so lists fill up
  localparam int SETTLE_CYCLES  = 40;   // longest walk plus margin
  localparam int HOLD_AFTER     = 120;  // replies seen before the long stall
  localparam int HOLD_CYCLES    = 240;
  localparam int IDLE_LIMIT     = 3000;
  localparam int MAX_REPORTS    = 10;
  localparam int MAX_GAP        = 11;
  localparam logic [1:0] KIND_NONE = 2'd3;  // unused code, the block drops it

  // One result beat, as predicted or as seen on m_tdata / m_tlast.
  typedef struct packed {
    logic                found;
    logic [POS_W-1:0]    pos;
    logic [VERT_W-1:0]   nb;
    logic [WEIGHT_W-1:0] weight;
    logic [ID_W-1:0]     id;
    status_t             st;
    logic                last;
  } reply_t;

  // One row of the directed table. Rows marked fixed carry their single
  // reply written out; all other rows are checked against the mirror.
  typedef struct {
    logic [1:0]          kind;
    logic [VERT_W-1:0]   src;
    logic [VERT_W-1:0]   dst;
    logic [WEIGHT_W-1:0] weight;
    int                  reps;
    bit                  fixed;
    bit                  found;
    logic [ID_W-1:0]     id;
    status_t             st;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  // Mirror of the edge store.
  logic [VERT_W-1:0]   adj_dst    [VERTICES][MAX_DEG];
  logic [WEIGHT_W-1:0] adj_weight [VERTICES][MAX_DEG];
  logic [ID_W-1:0]     adj_id     [VERTICES][MAX_DEG];
  int                  adj_len    [VERTICES];
  logic [ID_W-1:0]     last_id = '0;
  bit                  weighted = 1'b0;

  reply_t pending_replies [$];
  step_t  dir_tab [13];

  bit tx_burst = 1'b0;
  int errors = 0;
  int replies_seen = 0;
  int idle_cycles = 0;
  int n_insert = 0, n_query = 0, n_list = 0, n_ignored = 0;
  int n_range = 0, n_full = 0, n_no_edge = 0, n_weightless = 0;

  always #(PERIOD / 2) clk = ~clk;

  adjacency_list_edge_store_top #(
    .VERTEX_COUNT (VERTICES),
    .MAX_DEGREE   (MAX_DEG)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Work out the replies one accepted beat causes and advance the mirror.
  // With keep low the mirror still advances but the replies are dropped,
  // since the caller queues a hand-written reply instead.
  function automatic void predict_replies(logic [1:0] kind, logic [VERT_W-1:0] src,
                                          logic [VERT_W-1:0] dst,
                                          logic [WEIGHT_W-1:0] wt, bit keep);
    reply_t r;
    reply_t outs [$];
    int v;
    int len;
    int hit_pos;
    bit hit;
    r = '0;
    r.last = 1'b1;
    hit = 1'b0;
    hit_pos = 0;
    if (kind == KIND_NONE) return;
    if (src == '0 || int'(src) > VERTICES ||
        (kind != KIND_LIST && (dst == '0 || int'(dst) > VERTICES))) begin
      r.st = ST_RANGE;
      n_range++;
      outs = {outs, r};
    end else begin
      v = int'(src) - 1;
      len = adj_len[v];
      case (kind)
        KIND_INSERT: begin
          if (len >= MAX_DEG) begin
            r.st = ST_FULL;
            n_full++;
          end else begin
            last_id = last_id + 1'b1;  // wraps within the id width
            adj_dst[v][len] = dst;
            adj_weight[v][len] = wt;
            adj_id[v][len] = last_id;
            adj_len[v] = len + 1;
            r.id = last_id;
          end
          outs = {outs, r};
        end
        KIND_QUERY: begin
          // first match in stored order wins
          for (int i = 0; i < len; i++) begin
            if (!hit && adj_dst[v][i] == dst) begin
              hit = 1'b1;
              hit_pos = i;
            end
          end
          if (!weighted) begin
            r.found = hit;
            r.pos = POS_W'(hit_pos);
            r.st = ST_WEIGHTLESS;
            n_weightless++;
          end else if (!hit) begin
            r.st = ST_NO_EDGE;
            n_no_edge++;
          end else begin
            r.found = 1'b1;
            r.pos = POS_W'(hit_pos);
            r.weight = adj_weight[v][hit_pos];
          end
          outs = {outs, r};
        end
        default: begin
          // empty list answers with one beat, found low
          if (len == 0) outs = {outs, r};
          for (int i = 0; i < len; i++) begin
            r.found = 1'b1;
            r.pos = POS_W'(i);
            r.nb = adj_dst[v][i];
            r.weight = adj_weight[v][i];
            r.id = adj_id[v][i];
            r.last = (i == len - 1);
            outs = {outs, r};
          end
        end
      endcase
    end
    if (keep) begin
      foreach (outs[i]) pending_replies = {pending_replies, outs[i]};
    end
  endfunction

  // Offer one beat after a random gap and hold it until accepted. Return in
  // the step of the accepting edge, so the caller drives the next beat (or
  // drops valid) before the block can see this one twice.
  task automatic issue(input logic [1:0] kind, input logic [VERT_W-1:0] src,
                       input logic [VERT_W-1:0] dst, input logic [WEIGHT_W-1:0] wt,
                       input bit keep);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'd0, wt, dst, src};
    // sample the handshake mid-cycle, where everything has settled
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    predict_replies(kind, src, dst, wt, keep);
    case (kind)
      KIND_INSERT: n_insert++;
      KIND_QUERY:  n_query++;
      KIND_LIST:   n_list++;
      default:     n_ignored++;
    endcase
  endtask

  // Drop valid, wait out every expected reply, then let any walk that has
  // no reply of its own finish.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_weighted(input bit value);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    weighted = value;
  endtask

  task automatic flag_reply(input string what, input reply_t want, input reply_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("tb: %s at %0t", what, $time);
      $display("  want found=%0d pos=%0d nb=%0d w=%h id=%0d st=%0d last=%0d",
               want.found, want.pos, want.nb, want.weight, want.id, want.st, want.last);
      $display("  got  found=%0d pos=%0d nb=%0d w=%h id=%0d st=%0d last=%0d",
               got.found, got.pos, got.nb, got.weight, got.id, got.st, got.last);
    end
  endtask

  // Stimulus: directed table, then three random phases.
  initial begin
    reply_t            fixed_reply;
    logic [1:0]        kind;
    logic [VERT_W-1:0] src, dst, bad;
    logic [WEIGHT_W-1:0] wt;
    int                pick;
    int                n;

    foreach (adj_len[i]) adj_len[i] = 0;

    dir_tab = '{
      // empty list right after reset: one beat, found low
      '{KIND_LIST,   9'd1,   9'd0,   64'd0, 1, 1'b1, 1'b0, 13'd0, ST_OK},
      // query on an empty list of an unweighted graph
      '{KIND_QUERY,  9'd1,   9'd1,   64'd0, 1, 1'b1, 1'b0, 13'd0, ST_WEIGHTLESS},
      // first insert takes id 1; top vertex, top destination, all-ones weight
      '{KIND_INSERT, 9'd256, 9'd256, 64'hFFFF_FFFF_FFFF_FFFF,
        1, 1'b1, 1'b0, 13'd1, ST_OK},
      // range errors on source and destination
      '{KIND_INSERT, 9'd0,   9'd5,   64'd7, 1, 1'b1, 1'b0, 13'd0, ST_RANGE},
      '{KIND_INSERT, 9'd511, 9'd511, 64'd7, 1, 1'b1, 1'b0, 13'd0, ST_RANGE},
      '{KIND_QUERY,  9'd256, 9'd0,   64'd0, 1, 1'b1, 1'b0, 13'd0, ST_RANGE},
      '{KIND_QUERY,  9'd1,   9'd300, 64'd0, 1, 1'b1, 1'b0, 13'd0, ST_RANGE},
      '{KIND_LIST,   9'd0,   9'd256, 64'd0, 1, 1'b1, 1'b0, 13'd0, ST_RANGE},
      // unused kind: no reply, no change
      '{KIND_NONE,   9'd511, 9'd511, 64'hFFFF_FFFF_FFFF_FFFF,
        1, 1'b1, 1'b0, 13'd0, ST_OK},
      // fill the top vertex to capacity
      '{KIND_INSERT, 9'd256, 9'd1,   64'h8000_0000_0000_0001,
        MAX_DEG - 1, 1'b0, 1'b0, 13'd0, ST_OK},
      // one more is refused
      '{KIND_INSERT, 9'd256, 9'd2,   64'd0, 1, 1'b1, 1'b0, 13'd0, ST_FULL},
      // full list walk, then a hit past the head while unweighted
      '{KIND_LIST,   9'd256, 9'd0,   64'd0, 1, 1'b0, 1'b0, 13'd0, ST_OK},
      '{KIND_QUERY,  9'd256, 9'd1,   64'd0, 1, 1'b0, 1'b0, 13'd0, ST_OK}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      for (int r = 0; r < dir_tab[i].reps; r++) begin
        issue(dir_tab[i].kind, dir_tab[i].src, dir_tab[i].dst,
              dir_tab[i].weight ^ 64'(r), !dir_tab[i].fixed);
        if (dir_tab[i].fixed && dir_tab[i].kind != KIND_NONE) begin
          fixed_reply = '0;
          fixed_reply.found = dir_tab[i].found;
          fixed_reply.id = dir_tab[i].id;
          fixed_reply.st = dir_tab[i].st;
          fixed_reply.last = 1'b1;
          pending_replies = {pending_replies, fixed_reply};
        end
      end
    end

    // Random phases: weighted, unweighted, weighted again. Most beats are
    // well-formed and aimed at a few hot sources so lists grow, hit, and fill.
    for (int ph = 0; ph < 3; ph++) begin
      write_weighted(ph % 2 == 0);
      n = 0;
      while (n < RAND_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        src = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(1, VERTICES))
                                          : 9'($urandom_range(1, HOT_VERTICES));
        dst = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(1, VERTICES))
                                          : 9'($urandom_range(1, 8));
        wt = {$urandom, $urandom};
        case ($urandom_range(0, 9))
          0:       wt = '0;
          1:       wt = '1;
          default: ;
        endcase
        if (pick < 38) begin
          kind = KIND_INSERT;
        end else if (pick < 68) begin
          kind = KIND_QUERY;
        end else if (pick < 85) begin
          kind = KIND_LIST;
        end else if (pick < 90) begin
          kind = KIND_NONE;
          src = 9'($urandom);
          dst = 9'($urandom);
        end else begin
          // noise: a zero or oversized vertex on one side
          kind = 2'($urandom_range(0, 2));
          bad = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(VERTICES + 1, 511));
          if ($urandom_range(0, 1)) src = bad;
          else dst = bad;
        end
        issue(kind, src, dst, wt, 1'b1);
        if (kind != KIND_NONE) n++;
      end
    end

    quiesce();
    $display("tb: %0d beats in (%0d insert, %0d query, %0d list, %0d dropped), %0d replies",
             n_insert + n_query + n_list + n_ignored, n_insert, n_query, n_list,
             n_ignored, replies_seen);
    $display("tb: %0d range errors, %0d full-list refusals, %0d misses, %0d weightless",
             n_range, n_full, n_no_edge, n_weightless);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Result side: random ready gaps, bursts without gaps, and one long stall
  // that backs the block up until it stops taking input.
  initial begin : sink
    int     gap;
    bit     burst;
    bit     held;
    reply_t got;
    reply_t want;
    burst = 1'b0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && replies_seen >= HOLD_AFTER) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if ($urandom_range(0, 15) == 0) burst = !burst;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      // beat is taken at the coming edge; fields are stable now
      got.found  = m_tdata[0];
      got.pos    = m_tdata[4:1];
      got.nb     = m_tdata[13:5];
      got.weight = m_tdata[77:14];
      got.id     = m_tdata[90:78];
      got.st     = status_t'(m_tdata[93:91]);
      got.last   = m_tlast;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        flag_reply("reply with nothing expected", '0, got);
      end else begin
        want = pending_replies.pop_front();
        if (got.found !== want.found || got.pos !== want.pos || got.nb !== want.nb ||
            got.weight !== want.weight || got.id !== want.id || got.st !== want.st ||
            got.last !== want.last) begin
          flag_reply("reply mismatch", want, got);
        end
      end
      @(posedge clk);
    end
  end

  // Watchdog: count cycles with no beat on any channel. Covers the clearing
  // sweep after reset, the long stall and the drain waits.
  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("tb: no beat for %0d cycles, %0d replies outstanding",
                 IDLE_LIMIT, pending_replies.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

endmodule

[adjacency_list_edge_store_top.f]
+incdir+rtl
rtl/ales_pkg.sv
rtl/adjacency_list_edge_store_top.sv
test/tb.sv
